/* hdl/cruise_bang_bang_controller_top_macros.svh */
// Assertion macros shared by the controller top level.
`ifndef CRUISE_BANG_BANG_CONTROLLER_TOP_MACROS_SVH
`define CRUISE_BANG_BANG_CONTROLLER_TOP_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define CBB_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a condition in the cycle after its trigger.
`define CBB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/cbb_pkg.sv */
package cbb_pkg;

	// Event codes carried in the op field
	typedef enum logic [2:0] {
		OP_TICK       = 3'd0,
		OP_ACTIVATE   = 3'd1,
		OP_DEACTIVATE = 3'd2,
		OP_UP         = 3'd3,
		OP_DOWN       = 3'd4,
		OP_MANUAL     = 3'd5
	} op_t;

	// Status LED codes
	typedef enum logic [1:0] {
		LED_NONE  = 2'd0,
		LED_RED   = 2'd1,
		LED_GREEN = 2'd2,
		LED_BLUE  = 2'd3
	} led_t;

	// Configuration register indexes
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_DEADBAND     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ON_DUTY      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OFF_DUTY     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_INCR  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD_TICKS = 3'd5;

	// Register and state reset values
	localparam logic [7:0]  RST_DEADBAND     = 8'd5;
	localparam logic [6:0]  RST_ON_DUTY      = 7'd80;
	localparam logic [6:0]  RST_OFF_DUTY     = 7'd0;
	localparam logic [9:0]  RST_TARGET_INCR  = 10'd10;
	localparam logic [9:0]  RST_SPEED_LIMIT  = 10'd300;
	localparam logic [15:0] RST_PERIOD_TICKS = 16'd1000;
	localparam logic [9:0]  RST_TARGET       = 10'd100;

	// Duty ceiling in percent
	localparam logic [6:0] DUTY_MAX = 7'd100;

	// Divide by 100: floor(x * RECIP_K / 2^RECIP_SHIFT) is exact for x below 2^23
	localparam int          RECIP_SHIFT = 30;
	localparam logic [23:0] RECIP_K     = 24'd10737419;

	typedef struct packed {
		logic [7:0]  deadband;
		logic [6:0]  on_duty;
		logic [6:0]  off_duty;
		logic [9:0]  target_incr;
		logic [9:0]  speed_limit;
		logic [15:0] period_ticks;
	} cfg_regs_t;

	// Classified item passed from front to back
	typedef struct packed {
		logic       upd;
		logic [6:0] duty;
		led_t       led;
		logic       cruise_on;
		logic [9:0] target;
	} ctl_t;

	// Controller state seen by the top level
	typedef struct packed {
		logic       active;
		logic [9:0] target;
	} front_status_t;

endpackage

/* hdl/cbb_if.sv */
// Command channel: one event per item
interface cbb_cmd_if;
	logic        valid;
	logic        ready;
	logic [2:0]  op;
	logic [15:0] measured_rpm;
	logic [6:0]  pedal_pct;
	modport source (output valid, output op, output measured_rpm, output pedal_pct,
		input ready);
	modport sink (input valid, input op, input measured_rpm, input pedal_pct,
		output ready);
endinterface

// Result channel: one result per event
interface cbb_res_if;
	logic        valid;
	logic        ready;
	logic [15:0] compare_value;
	logic        compare_update;
	logic        cruise_on;
	logic [9:0]  target_now;
	logic [1:0]  led_color;
	modport source (output valid, output compare_value, output compare_update,
		output cruise_on, output target_now, output led_color, input ready);
	modport sink (input valid, input compare_value, input compare_update,
		input cruise_on, input target_now, input led_color, output ready);
endinterface

// Configuration write channel
interface cbb_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [15:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* hdl/cbb_front.sv */
module cbb_front
	import cbb_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	cbb_cmd_if.sink       cmd,
	input  cfg_regs_t     regs,
	input  logic          full,
	output logic          push,
	output ctl_t          push_data,
	output front_status_t st
);

	logic       active_q;
	logic [9:0] target_q;
	logic       active_d;
	logic [9:0] target_d;
	logic [16:0] rpm_plus_db;
	logic [10:0] upper;
	logic [10:0] up_sum;
	logic [6:0] on_clamp;
	logic [6:0] off_clamp;
	logic [6:0] pedal_clamp;
	op_t        op;

	// Take an item whenever the queue has room
	assign cmd.ready = !full;
	assign push      = cmd.valid && !full;
	assign op        = op_t'(cmd.op);

	// Clamp duties to 100 percent
	assign on_clamp    = (regs.on_duty > DUTY_MAX) ? DUTY_MAX : regs.on_duty;
	assign off_clamp   = (regs.off_duty > DUTY_MAX) ? DUTY_MAX : regs.off_duty;
	assign pedal_clamp = (cmd.pedal_pct > DUTY_MAX) ? DUTY_MAX : cmd.pedal_pct;

	// Band edges: rpm below target - deadband when rpm + deadband < target
	assign rpm_plus_db = {1'b0, cmd.measured_rpm} + {9'd0, regs.deadband};
	assign upper       = {1'b0, target_q} + {3'd0, regs.deadband};
	assign up_sum      = {1'b0, target_q} + {1'b0, regs.target_incr};

	// Classify the event and work out the next state
	always_comb begin
		active_d           = active_q;
		target_d           = target_q;
		push_data.upd      = 1'b0;
		push_data.duty     = off_clamp;
		push_data.led      = LED_NONE;
		unique case (op)
			OP_TICK: begin
				if (active_q) begin
					if (rpm_plus_db < {7'd0, target_q}) begin
						push_data.upd  = 1'b1;
						push_data.duty = on_clamp;
						push_data.led  = LED_BLUE;
					end else if ({1'b0, cmd.measured_rpm} > {6'd0, upper}) begin
						push_data.upd  = 1'b1;
						push_data.duty = off_clamp;
						push_data.led  = LED_GREEN;
					end
				end
			end
			OP_ACTIVATE: begin
				active_d = 1'b1;
			end
			OP_DEACTIVATE: begin
				active_d       = 1'b0;
				push_data.upd  = 1'b1;
				push_data.duty = off_clamp;
				push_data.led  = LED_RED;
			end
			OP_UP: begin
				target_d = (up_sum <= {1'b0, regs.speed_limit}) ? up_sum[9:0]
					: regs.speed_limit;
			end
			OP_DOWN: begin
				target_d = (target_q >= regs.target_incr) ? target_q - regs.target_incr
					: 10'd0;
			end
			OP_MANUAL: begin
				if (!active_q) begin
					push_data.upd  = 1'b1;
					push_data.duty = pedal_clamp;
				end
			end
			default: begin
			end
		endcase
		push_data.cruise_on = active_d;
		push_data.target    = target_d;
	end

	// Advance controller state on accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			target_q <= RST_TARGET;
		end else if (push) begin
			active_q <= active_d;
			target_q <= target_d;
		end
	end

	assign st.active = active_q;
	assign st.target = target_q;

endmodule

/* hdl/cbb_queue.sv */
module cbb_queue
	import cbb_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  ctl_t push_data,
	input  logic pop,
	output ctl_t pop_data,
	output logic full,
	output logic empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	ctl_t             entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (count_q == FULL_CNT);
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = entry_q[rd_ptr_q];

	// Store pushed items
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* hdl/cbb_back.sv */
module cbb_back
	import cbb_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_regs_t regs,
	input  ctl_t      pop_data,
	input  logic      avail,
	output logic      pop,
	cbb_res_if.source res
);

	logic        en;
	logic        v_s1;
	logic        v_s2;
	logic        valid_q;
	ctl_t        ctl_s1;
	ctl_t        ctl_s2;
	logic [22:0] prod_s1;
	logic [15:0] ticks_s2;
	logic [46:0] recip_prod;
	logic [15:0] ticks_lim;
	logic [15:0] cmp_d;
	logic [15:0] cmp_q;
	ctl_t        ctl_q;

	// Whole pipeline moves when the output register is free or being taken
	assign en  = !valid_q || res.ready;
	assign pop = en && avail;

	// Divide the duty product by 100 through the reciprocal
	assign recip_prod = {24'd0, prod_s1} * {23'd0, RECIP_K};

	// Limit ticks to period - 1 and invert into the compare word
	always_comb begin
		ticks_lim = (ticks_s2 >= regs.period_ticks) ? regs.period_ticks - 16'd1 : ticks_s2;
		if (!ctl_s2.upd || regs.period_ticks == 16'd0) begin
			cmp_d = 16'd0;
		end else begin
			cmp_d = regs.period_ticks - 16'd1 - ticks_lim;
		end
	end

	// Hold valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			valid_q <= 1'b0;
		end else if (en) begin
			v_s1    <= avail;
			v_s2    <= v_s1;
			valid_q <= v_s2;
		end
	end

	// Advance payload through multiply, divide and compare stages
	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1   <= pop_data;
			prod_s1  <= {16'd0, pop_data.duty} * {7'd0, regs.period_ticks};
			ctl_s2   <= ctl_s1;
			ticks_s2 <= recip_prod[RECIP_SHIFT+15:RECIP_SHIFT];
			ctl_q    <= ctl_s2;
			cmp_q    <= cmp_d;
		end
	end

	assign res.valid          = valid_q;
	assign res.compare_value  = cmp_q;
	assign res.compare_update = ctl_q.upd;
	assign res.cruise_on      = ctl_q.cruise_on;
	assign res.target_now     = ctl_q.target;
	assign res.led_color      = ctl_q.led;

endmodule

/* hdl/cruise_bang_bang_controller_top.sv */
// Cruise controller with a deadband around the target speed.
// Channels: cmd takes one event per item (op, measured_rpm, pedal_pct); res returns
// exactly one item per event, in order (compare word, update flag, cruise flag,
// target, LED code); cfg writes register <index> with <data> and is always ready.
// Registers: 0 deadband, 1 on duty, 2 off duty, 3 speed step, 4 speed limit,
// 5 PWM period. Write them only while no event is in flight.
// Path: an accepted event is written into the queue, then passes the duty multiply,
// the divide by 100 and the compare output register before its result is valid.
// Throughput: one event per cycle while the queue has room; the front updates cruise
// state in the cycle it accepts an event, and the back is a three-stage pipeline.
// Stall: while res is held the back pipeline freezes; the queue between front
// and back then fills and cmd.ready drops once it is full.
// Reset: cruise off, target 100, registers at their defaults, queue and
// pipeline empty.
`include "cruise_bang_bang_controller_top_macros.svh"

module cruise_bang_bang_controller_top
	import cbb_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic      clk,
	input  logic      arst_n,
	cbb_cmd_if.sink   cmd,
	cbb_res_if.source res,
	cbb_cfg_if.sink   cfg
);

	cfg_regs_t     regs_q;
	ctl_t          push_data;
	ctl_t          pop_data;
	logic          push;
	logic          pop;
	logic          full;
	logic          empty;
	front_status_t st;

	// Accept register writes every cycle
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.deadband     <= RST_DEADBAND;
			regs_q.on_duty      <= RST_ON_DUTY;
			regs_q.off_duty     <= RST_OFF_DUTY;
			regs_q.target_incr  <= RST_TARGET_INCR;
			regs_q.speed_limit  <= RST_SPEED_LIMIT;
			regs_q.period_ticks <= RST_PERIOD_TICKS;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_DEADBAND:     regs_q.deadband     <= cfg.data[7:0];
				REG_ON_DUTY:      regs_q.on_duty      <= cfg.data[6:0];
				REG_OFF_DUTY:     regs_q.off_duty     <= cfg.data[6:0];
				REG_TARGET_INCR:  regs_q.target_incr  <= cfg.data[9:0];
				REG_SPEED_LIMIT:  regs_q.speed_limit  <= cfg.data[9:0];
				REG_PERIOD_TICKS: regs_q.period_ticks <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	cbb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.regs      (regs_q),
		.full      (full),
		.push      (push),
		.push_data (push_data),
		.st        (st)
	);

	cbb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.full      (full),
		.empty     (empty)
	);

	cbb_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.regs     (regs_q),
		.pop_data (pop_data),
		.avail    (!empty),
		.pop      (pop),
		.res      (res)
	);

	// A result without a compare write carries a zero word and no LED change
	`CBB_ASSERT_NOW(a_no_update_zero, res.valid && !res.compare_update, res.compare_value == 16'd0 && res.led_color == LED_NONE, "result without update carries data")
	// A written compare word stays below a nonzero period and is zero for a zero period
	`CBB_ASSERT_NOW(a_cmp_in_period, res.valid && res.compare_update, res.compare_value < regs_q.period_ticks || (regs_q.period_ticks == 16'd0 && res.compare_value == 16'd0), "compare word out of period")
	// Deactivate always clears the cruise flag
	`CBB_ASSERT_NEXT(a_deact_clears, cmd.valid && cmd.ready && cmd.op == OP_DEACTIVATE, !st.active, "cruise still active after deactivate")
	// Target up never leaves the target above the limit
	`CBB_ASSERT_NEXT(a_up_limited, cmd.valid && cmd.ready && cmd.op == OP_UP, st.target <= regs_q.speed_limit, "target above limit after step up")

endmodule
